// ===== rtl/fcl_pkg.sv =====
`default_nettype none

package fcl_pkg;

  localparam int CW = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NSLOT = 4;
  localparam int CUT_LAT = PW + 3;
  localparam int PIPE_LAT = 1 + NSLOT * CUT_LAT + 1;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'({1'b0, {(CW-1){1'b1}}});
  localparam coord_t COORD_MIN = coord_t'({1'b1, {(CW-1){1'b0}}});

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam coord_t WIN_LEFT_RST   = '0;
  localparam coord_t WIN_BOTTOM_RST = '0;
  localparam coord_t WIN_RIGHT_RST  = COORD_MAX;
  localparam coord_t WIN_TOP_RST    = COORD_MAX;

  localparam logic PT_S = 1'b0;
  localparam logic PT_E = 1'b1;

  typedef enum logic [1:0] {
    SIDE_L,
    SIDE_B,
    SIDE_R,
    SIDE_T
  } side_e;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } line_t;

  typedef struct packed {
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
    logic   visible;
  } clip_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } win_t;

  typedef struct packed {
    logic  cut_en;
    logic  cut_cond;
    logic  cut_pt;
    side_e cut_side;
    logic  rej_en;
    logic  rej_pt;
    side_e rej_side;
  } slot_t;

  typedef struct packed {
    slot_t [NSLOT-1:0] slot;
  } plan_t;

  typedef struct packed {
    line_t  orig;
    coord_t px0;
    coord_t py0;
    coord_t px1;
    coord_t py1;
    logic   rej;
    plan_t  plan;
  } seg_t;

  typedef struct packed {
    seg_t   seg;
    coord_t base;
    coord_t e;
    logic   neg;
    logic   den_zero;
    logic   do_cut;
    logic   horiz;
    logic   pt;
  } cutctx_t;

  function automatic coord_t side_val(side_e sd, win_t w);
    coord_t v;
    case (sd)
      SIDE_L:  v = w.left;
      SIDE_B:  v = w.bottom;
      SIDE_R:  v = w.right;
      SIDE_T:  v = w.top;
      default: v = w.left;
    endcase
    return v;
  endfunction

  // point lies beyond the given window side
  function automatic logic guard(side_e sd, coord_t x, coord_t y, win_t w);
    logic g;
    case (sd)
      SIDE_L:  g = x < w.left;
      SIDE_B:  g = y < w.bottom;
      SIDE_R:  g = x > w.right;
      SIDE_T:  g = y > w.top;
      default: g = 1'b0;
    endcase
    return g;
  endfunction

  function automatic logic signed [DW-1:0] ext(coord_t v);
    return {v[CW-1], v};
  endfunction

  function automatic slot_t cut_a(logic pt, side_e sd);
    slot_t s;
    s = '0;
    s.cut_en = 1'b1;
    s.cut_pt = pt;
    s.cut_side = sd;
    return s;
  endfunction

  function automatic slot_t cut_c(logic pt, side_e sd);
    slot_t s;
    s = cut_a(pt, sd);
    s.cut_cond = 1'b1;
    return s;
  endfunction

  function automatic slot_t with_rej(slot_t s, logic pt, side_e sd);
    slot_t r;
    r = s;
    r.rej_en = 1'b1;
    r.rej_pt = pt;
    r.rej_side = sd;
    return r;
  endfunction

  // region code pair to cut program, trivial flags rejection
  function automatic plan_t plan(logic [7:0] code, output logic trivial);
    plan_t p;
    p = '0;
    trivial = 1'b0;
    case (code)
      8'h00: ;
      8'h01: p.slot[0] = cut_a(PT_E, SIDE_L);
      8'h02: p.slot[0] = cut_a(PT_E, SIDE_R);
      8'h04: p.slot[0] = cut_a(PT_E, SIDE_B);
      8'h05: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = cut_c(PT_E, SIDE_B);
      end
      8'h06: begin
        p.slot[0] = cut_a(PT_E, SIDE_R);
        p.slot[1] = cut_c(PT_E, SIDE_B);
      end
      8'h08: p.slot[0] = cut_a(PT_E, SIDE_T);
      8'h09: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = cut_c(PT_E, SIDE_T);
      end
      8'h0A: begin
        p.slot[0] = cut_a(PT_E, SIDE_R);
        p.slot[1] = cut_c(PT_E, SIDE_T);
      end
      8'h10: p.slot[0] = cut_a(PT_S, SIDE_L);
      8'h12: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = cut_a(PT_E, SIDE_R);
      end
      8'h14: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_B), PT_S, SIDE_B);
      end
      8'h16: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_B), PT_S, SIDE_B);
        p.slot[2] = cut_c(PT_E, SIDE_R);
      end
      8'h18: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_T), PT_S, SIDE_T);
      end
      8'h1A: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_T), PT_S, SIDE_T);
        p.slot[2] = cut_c(PT_E, SIDE_R);
      end
      8'h20: p.slot[0] = cut_a(PT_S, SIDE_R);
      8'h21: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = cut_a(PT_E, SIDE_L);
      end
      8'h24: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_B), PT_S, SIDE_B);
      end
      8'h25: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_B), PT_S, SIDE_B);
        p.slot[2] = cut_c(PT_E, SIDE_L);
      end
      8'h28: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_T), PT_S, SIDE_T);
      end
      8'h29: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_T), PT_S, SIDE_T);
        p.slot[2] = cut_c(PT_E, SIDE_L);
      end
      8'h40: p.slot[0] = cut_a(PT_S, SIDE_B);
      8'h41: begin
        p.slot[0] = cut_a(PT_S, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_L), PT_S, SIDE_L);
        p.slot[2] = cut_c(PT_E, SIDE_B);
      end
      8'h42: begin
        p.slot[0] = cut_a(PT_S, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_R);
      end
      8'h48: begin
        p.slot[0] = cut_a(PT_S, SIDE_B);
        p.slot[1] = cut_a(PT_E, SIDE_T);
      end
      8'h49: begin
        p.slot[0] = cut_a(PT_S, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_L), PT_S, SIDE_L);
        p.slot[2] = cut_c(PT_E, SIDE_T);
      end
      8'h4A: begin
        p.slot[0] = cut_a(PT_S, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_R);
        p.slot[2] = cut_c(PT_E, SIDE_T);
      end
      8'h50: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = cut_c(PT_S, SIDE_B);
      end
      8'h52: begin
        p.slot[0] = cut_a(PT_E, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_B), PT_E, SIDE_B);
        p.slot[2] = cut_c(PT_S, SIDE_L);
      end
      8'h58: begin
        p.slot[0] = cut_a(PT_E, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_B), PT_E, SIDE_L);
        p.slot[2] = cut_c(PT_S, SIDE_L);
      end
      8'h5A: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_T);
        p.slot[2] = with_rej(cut_c(PT_S, SIDE_B), PT_E, SIDE_B);
        p.slot[3] = cut_c(PT_E, SIDE_T);
      end
      8'h60: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = cut_c(PT_S, SIDE_B);
      end
      8'h61: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_B), PT_E, SIDE_B);
        p.slot[2] = cut_c(PT_S, SIDE_R);
      end
      8'h68: begin
        p.slot[0] = cut_a(PT_E, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_R), PT_E, SIDE_R);
        p.slot[2] = cut_c(PT_S, SIDE_B);
      end
      8'h69: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_R), PT_E, SIDE_B);
        p.slot[2] = with_rej(cut_c(PT_E, SIDE_T), PT_S, SIDE_T);
        p.slot[3] = cut_c(PT_S, SIDE_B);
      end
      8'h80: p.slot[0] = cut_a(PT_S, SIDE_T);
      8'h81: begin
        p.slot[0] = cut_a(PT_S, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_L), PT_S, SIDE_L);
      end
      8'h82: begin
        p.slot[0] = cut_a(PT_S, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_R);
      end
      8'h84: begin
        p.slot[0] = cut_a(PT_S, SIDE_T);
        p.slot[1] = cut_a(PT_E, SIDE_B);
      end
      8'h85: begin
        p.slot[0] = cut_a(PT_S, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_L), PT_S, SIDE_L);
        p.slot[2] = cut_c(PT_E, SIDE_B);
      end
      8'h86: begin
        p.slot[0] = cut_a(PT_S, SIDE_T);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_R);
        p.slot[2] = cut_c(PT_E, SIDE_B);
      end
      8'h90: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = cut_c(PT_S, SIDE_T);
      end
      8'h92: begin
        p.slot[0] = cut_a(PT_E, SIDE_R);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_T), PT_E, SIDE_T);
        p.slot[2] = cut_c(PT_S, SIDE_L);
      end
      8'h94: begin
        p.slot[0] = cut_a(PT_E, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_L), PT_E, SIDE_L);
        p.slot[2] = cut_c(PT_S, SIDE_T);
      end
      8'h96: begin
        p.slot[0] = cut_a(PT_S, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_E, SIDE_R), PT_S, SIDE_B);
        p.slot[2] = with_rej(cut_c(PT_S, SIDE_T), PT_E, SIDE_T);
        p.slot[3] = cut_c(PT_E, SIDE_B);
      end
      8'hA0: begin
        p.slot[0] = cut_a(PT_S, SIDE_R);
        p.slot[1] = cut_c(PT_S, SIDE_T);
      end
      8'hA1: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_T), PT_E, SIDE_T);
        p.slot[2] = cut_c(PT_S, SIDE_R);
      end
      8'hA4: begin
        p.slot[0] = cut_a(PT_E, SIDE_B);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_R), PT_E, SIDE_R);
        p.slot[2] = cut_c(PT_S, SIDE_T);
      end
      8'hA5: begin
        p.slot[0] = cut_a(PT_E, SIDE_L);
        p.slot[1] = with_rej(cut_a(PT_S, SIDE_R), PT_E, SIDE_T);
        p.slot[2] = with_rej(cut_c(PT_E, SIDE_B), PT_S, SIDE_B);
        p.slot[3] = cut_c(PT_S, SIDE_T);
      end
      default: trivial = 1'b1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fast_line_clip.sv =====
// every accepted start yields its own done_o beat
// throughput: one segment per cycle, busy is never raised
// four cut units in series, each a multiply and a 34 stage divider
// reset loads the default window and clears all valid bits; segments in flight are dropped
// done_o and clip_o show each result for one cycle only, the receiver cannot stall
`default_nettype none

module fast_line_clip (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire fcl_pkg::line_t                   line_i,
  output logic                                  done_o,
  output fcl_pkg::clip_t                        clip_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [fcl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [fcl_pkg::CW-1:0]           cfg_data_i
);

  fcl_pkg::win_t win_d, win_q;

  always_comb begin
    win_d = win_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fcl_pkg::REG_LEFT:   win_d.left = cfg_data_i;
        fcl_pkg::REG_BOTTOM: win_d.bottom = cfg_data_i;
        fcl_pkg::REG_RIGHT:  win_d.right = cfg_data_i;
        fcl_pkg::REG_TOP:    win_d.top = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.left <= fcl_pkg::WIN_LEFT_RST;
      win_q.bottom <= fcl_pkg::WIN_BOTTOM_RST;
      win_q.right <= fcl_pkg::WIN_RIGHT_RST;
      win_q.top <= fcl_pkg::WIN_TOP_RST;
    end else begin
      win_q <= win_d;
    end
  end

  assign busy = 1'b0;

  logic          vld_w [fcl_pkg::NSLOT+1];
  fcl_pkg::seg_t seg_w [fcl_pkg::NSLOT+1];

  fcl_classify u_classify (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win_q),
    .valid_i(start && !busy),
    .line_i (line_i),
    .valid_o(vld_w[0]),
    .seg_o  (seg_w[0])
  );

  for (genvar k = 0; k < fcl_pkg::NSLOT; k++) begin : g_cut
    fcl_cut u_cut (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .win_i  (win_q),
      .valid_i(vld_w[k]),
      .seg_i  (seg_w[k]),
      .valid_o(vld_w[k+1]),
      .seg_o  (seg_w[k+1])
    );
  end

  fcl_pkg::seg_t last;
  fcl_pkg::clip_t clip_d, clip_q;
  logic done_q;

  always_comb begin
    last = seg_w[fcl_pkg::NSLOT];
    if (last.rej) begin
      clip_d.clipped_start_x = last.orig.start_x;
      clip_d.clipped_start_y = last.orig.start_y;
      clip_d.clipped_end_x = last.orig.end_x;
      clip_d.clipped_end_y = last.orig.end_y;
    end else begin
      clip_d.clipped_start_x = last.px0;
      clip_d.clipped_start_y = last.py0;
      clip_d.clipped_end_x = last.px1;
      clip_d.clipped_end_y = last.py1;
    end
    clip_d.visible = !last.rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_w[fcl_pkg::NSLOT];
    end
  end

  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
  end

  assign done_o = done_q;
  assign clip_o = clip_q;

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(fcl_pkg::PIPE_LAT) done_o)
    else $error("accepted segment produced no result beat");

  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, fcl_pkg::PIPE_LAT))
    else $error("result beat without a matching segment");

  a_reject_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !clip_o.visible |->
      clip_o.clipped_start_x == $past(line_i.start_x, fcl_pkg::PIPE_LAT) &&
      clip_o.clipped_start_y == $past(line_i.start_y, fcl_pkg::PIPE_LAT) &&
      clip_o.clipped_end_x == $past(line_i.end_x, fcl_pkg::PIPE_LAT) &&
      clip_o.clipped_end_y == $past(line_i.end_y, fcl_pkg::PIPE_LAT))
    else $error("rejected segment changed its endpoints");

endmodule

`default_nettype wire

// ===== rtl/fcl_classify.sv =====
`default_nettype none

module fcl_classify (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fcl_pkg::win_t win_i,
  input  wire logic          valid_i,
  input  wire fcl_pkg::line_t line_i,
  output logic               valid_o,
  output fcl_pkg::seg_t      seg_o
);

  logic [7:0] code;
  logic trivial;
  fcl_pkg::plan_t plan;
  fcl_pkg::seg_t seg_d;
  fcl_pkg::seg_t seg_q;
  logic valid_q;

  always_comb begin
    code[7] = line_i.start_y > win_i.top;
    code[6] = !code[7] && (line_i.start_y < win_i.bottom);
    code[5] = line_i.start_x > win_i.right;
    code[4] = !code[5] && (line_i.start_x < win_i.left);
    code[3] = line_i.end_y > win_i.top;
    code[2] = !code[3] && (line_i.end_y < win_i.bottom);
    code[1] = line_i.end_x > win_i.right;
    code[0] = !code[1] && (line_i.end_x < win_i.left);
    plan = fcl_pkg::plan(code, trivial);
    seg_d.orig = line_i;
    seg_d.px0 = line_i.start_x;
    seg_d.py0 = line_i.start_y;
    seg_d.px1 = line_i.end_x;
    seg_d.py1 = line_i.end_y;
    seg_d.rej = trivial;
    seg_d.plan = plan;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign valid_o = valid_q;
  assign seg_o = seg_q;

endmodule

`default_nettype wire

// ===== rtl/fcl_div.sv =====
`default_nettype none

module fcl_div #(
  parameter int NUM_W = fcl_pkg::PW,
  parameter int DEN_W = fcl_pkg::DW,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  num_in;
    logic [NUM_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      num_q[k] <= num_in << 1;
      quo_q[k] <= {quo_in[NUM_W-2:0], ge};
      den_q[k] <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o = quo_q[NUM_W-1];
  assign side_o = side_q[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/fcl_cut.sv =====
`default_nettype none

module fcl_cut (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fcl_pkg::win_t win_i,
  input  wire logic          valid_i,
  input  wire fcl_pkg::seg_t seg_i,
  output logic               valid_o,
  output fcl_pkg::seg_t      seg_o
);

  localparam int CW = fcl_pkg::CW;
  localparam int DW = fcl_pkg::DW;
  localparam int PW = fcl_pkg::PW;
  localparam int SideW = $bits(fcl_pkg::cutctx_t);
  localparam logic signed [CW+1:0] SumMax = (CW+2)'(fcl_pkg::COORD_MAX);
  localparam logic signed [CW+1:0] SumMin = (CW+2)'(fcl_pkg::COORD_MIN);

  // guard and operand stage
  fcl_pkg::slot_t s;
  fcl_pkg::coord_t rx, ry, cx, cy, ox, oy;
  fcl_pkg::coord_t base, obase, pos, opos;
  logic signed [DW-1:0] d, n, den;
  logic horiz, rej_hit;
  fcl_pkg::cutctx_t ctx_d;

  always_comb begin
    s = seg_i.plan.slot[0];
    rx = s.rej_pt ? seg_i.px1 : seg_i.px0;
    ry = s.rej_pt ? seg_i.py1 : seg_i.py0;
    cx = s.cut_pt ? seg_i.px1 : seg_i.px0;
    cy = s.cut_pt ? seg_i.py1 : seg_i.py0;
    ox = s.cut_pt ? seg_i.px0 : seg_i.px1;
    oy = s.cut_pt ? seg_i.py0 : seg_i.py1;
    rej_hit = s.rej_en && fcl_pkg::guard(s.rej_side, rx, ry, win_i);
    horiz = (s.cut_side == fcl_pkg::SIDE_B) || (s.cut_side == fcl_pkg::SIDE_T);
    base = horiz ? cx : cy;
    obase = horiz ? ox : oy;
    pos = horiz ? cy : cx;
    opos = horiz ? oy : ox;
    ctx_d.seg = seg_i;
    ctx_d.seg.rej = seg_i.rej | rej_hit;
    ctx_d.seg.plan.slot = {fcl_pkg::slot_t'('0), seg_i.plan.slot[fcl_pkg::NSLOT-1:1]};
    ctx_d.base = base;
    ctx_d.e = fcl_pkg::side_val(s.cut_side, win_i);
    d = fcl_pkg::ext(obase) - fcl_pkg::ext(base);
    n = fcl_pkg::ext(ctx_d.e) - fcl_pkg::ext(pos);
    den = fcl_pkg::ext(opos) - fcl_pkg::ext(pos);
    ctx_d.neg = d[DW-1] ^ n[DW-1] ^ den[DW-1];
    ctx_d.den_zero = den == '0;
    ctx_d.do_cut = !ctx_d.seg.rej && s.cut_en
                   && (!s.cut_cond || fcl_pkg::guard(s.cut_side, cx, cy, win_i));
    ctx_d.horiz = horiz;
    ctx_d.pt = s.cut_pt;
  end

  logic a_vld_q;
  fcl_pkg::cutctx_t a_ctx_q;
  logic [DW-1:0] a_dm_q, a_nm_q, a_denm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ctx_q <= ctx_d;
    a_dm_q <= d[DW-1] ? DW'(-d) : DW'(d);
    a_nm_q <= n[DW-1] ? DW'(-n) : DW'(n);
    a_denm_q <= den[DW-1] ? DW'(-den) : DW'(den);
  end

  // product stage
  logic b_vld_q;
  fcl_pkg::cutctx_t b_ctx_q;
  logic [PW-1:0] b_prod_q;
  logic [DW-1:0] b_denm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ctx_q <= a_ctx_q;
    b_prod_q <= PW'(a_dm_q) * PW'(a_nm_q);
    b_denm_q <= a_denm_q;
  end

  logic div_vld;
  logic [PW-1:0] quo;
  logic [SideW-1:0] div_side;

  fcl_div #(
    .NUM_W (PW),
    .DEN_W (DW),
    .SIDE_W(SideW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(b_vld_q),
    .num_i  (b_prod_q),
    .den_i  (b_denm_q),
    .side_i (SideW'(b_ctx_q)),
    .valid_o(div_vld),
    .quo_o  (quo),
    .side_o (div_side)
  );

  // offset, saturate and write back
  fcl_pkg::cutctx_t f_ctx;
  logic [DW-1:0] qc;
  logic signed [CW+1:0] sum;
  fcl_pkg::coord_t sat, nb;
  fcl_pkg::seg_t seg_d;

  always_comb begin
    f_ctx = fcl_pkg::cutctx_t'(div_side);
    qc = (|quo[PW-1:CW]) ? {1'b1, {CW{1'b0}}} : {1'b0, quo[CW-1:0]};
    if (f_ctx.neg) begin
      sum = (CW+2)'(f_ctx.base) - $signed({1'b0, qc});
    end else begin
      sum = (CW+2)'(f_ctx.base) + $signed({1'b0, qc});
    end
    if (sum > SumMax) begin
      sat = fcl_pkg::COORD_MAX;
    end else if (sum < SumMin) begin
      sat = fcl_pkg::COORD_MIN;
    end else begin
      sat = sum[CW-1:0];
    end
    nb = f_ctx.den_zero ? f_ctx.base : sat;
    seg_d = f_ctx.seg;
    if (f_ctx.do_cut) begin
      if (f_ctx.pt) begin
        if (f_ctx.horiz) begin
          seg_d.px1 = nb;
          seg_d.py1 = f_ctx.e;
        end else begin
          seg_d.py1 = nb;
          seg_d.px1 = f_ctx.e;
        end
      end else begin
        if (f_ctx.horiz) begin
          seg_d.px0 = nb;
          seg_d.py0 = f_ctx.e;
        end else begin
          seg_d.py0 = nb;
          seg_d.px0 = f_ctx.e;
        end
      end
    end
  end

  logic f_vld_q;
  fcl_pkg::seg_t f_seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_seg_q <= seg_d;
  end

  assign valid_o = f_vld_q;
  assign seg_o = f_seg_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

  localparam int LATENCY = 160;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 190;

  // region code bits, start point in the high nibble
  localparam int S_T = 128;
  localparam int S_B = 64;
  localparam int S_R = 32;
  localparam int S_L = 16;
  localparam int E_T = 8;
  localparam int E_B = 4;
  localparam int E_R = 2;
  localparam int E_L = 1;

  localparam longint C_MAX = 32767;
  localparam longint C_MIN = -32768;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  fcl_pkg::line_t line_i = '0;
  logic done_o;
  fcl_pkg::clip_t clip_o;
  logic cfg_we_i = 1'b0;
  logic [fcl_pkg::CFG_IDX_W-1:0] cfg_idx_i = fcl_pkg::REG_LEFT;
  logic [fcl_pkg::CW-1:0] cfg_data_i = '0;

  fcl_pkg::line_t pending_lines[$];
  fcl_pkg::clip_t clipped_q[$];
  int send_idle = 13;
  int fails = 0;
  int stall_cnt = 0;

  longint win_l = 0, win_b = 0, win_r = C_MAX, win_t = C_MAX;
  longint px[2], py[2];

  fast_line_clip i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .line_i(line_i),
    .done_o(done_o),
    .clip_o(clip_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint cross_pt(longint base, longint obase, longint edge_v,
                                      longint pos, longint opos);
    longint d, n, den, r;
    longint unsigned q;
    bit neg;
    d = obase - base;
    n = edge_v - pos;
    den = opos - pos;
    if (den == 0) return base;
    neg = ((d < 0) != (n < 0)) != (den < 0);
    q = (longint'(d < 0 ? -d : d) * longint'(n < 0 ? -n : n)) /
        longint'(den < 0 ? -den : den);
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    r = neg ? base - longint'(q) : base + longint'(q);
    if (r > C_MAX) r = C_MAX;
    if (r < C_MIN) r = C_MIN;
    return r;
  endfunction

  function automatic void cut_h(int i, longint e);
    px[i] = cross_pt(px[i], px[1-i], e, py[i], py[1-i]);
    py[i] = e;
  endfunction

  function automatic void cut_v(int i, longint e);
    py[i] = cross_pt(py[i], py[1-i], e, px[i], px[1-i]);
    px[i] = e;
  endfunction

  function automatic fcl_pkg::clip_t clip_line(fcl_pkg::line_t ln);
    fcl_pkg::clip_t c;
    int code;
    bit vis;
    longint L, B, R, T;
    L = win_l; B = win_b; R = win_r; T = win_t;
    px[0] = ln.start_x; py[0] = ln.start_y;
    px[1] = ln.end_x; py[1] = ln.end_y;
    code = 0;
    vis = 1'b0;
    if (py[1] > T) code += E_T; else if (py[1] < B) code += E_B;
    if (px[1] > R) code += E_R; else if (px[1] < L) code += E_L;
    if (py[0] > T) code += S_T; else if (py[0] < B) code += S_B;
    if (px[0] > R) code += S_R; else if (px[0] < L) code += S_L;
    case (code)
      0: vis = 1;
      E_L: begin cut_v(1, L); vis = 1; end
      E_R: begin cut_v(1, R); vis = 1; end
      E_B: begin cut_h(1, B); vis = 1; end
      E_B|E_L: begin cut_v(1, L); if (py[1] < B) cut_h(1, B); vis = 1; end
      E_B|E_R: begin cut_v(1, R); if (py[1] < B) cut_h(1, B); vis = 1; end
      E_T: begin cut_h(1, T); vis = 1; end
      E_T|E_L: begin cut_v(1, L); if (py[1] > T) cut_h(1, T); vis = 1; end
      E_T|E_R: begin cut_v(1, R); if (py[1] > T) cut_h(1, T); vis = 1; end
      S_L: begin cut_v(0, L); vis = 1; end
      S_L|E_R: begin cut_v(0, L); cut_v(1, R); vis = 1; end
      S_L|E_B: begin
        cut_v(0, L);
        if (!(py[0] < B)) begin cut_h(1, B); vis = 1; end
      end
      S_L|E_B|E_R: begin
        cut_v(0, L);
        if (!(py[0] < B)) begin
          cut_h(1, B); if (px[1] > R) cut_v(1, R); vis = 1;
        end
      end
      S_L|E_T: begin
        cut_v(0, L);
        if (!(py[0] > T)) begin cut_h(1, T); vis = 1; end
      end
      S_L|E_T|E_R: begin
        cut_v(0, L);
        if (!(py[0] > T)) begin
          cut_h(1, T); if (px[1] > R) cut_v(1, R); vis = 1;
        end
      end
      S_R: begin cut_v(0, R); vis = 1; end
      S_R|E_L: begin cut_v(0, R); cut_v(1, L); vis = 1; end
      S_R|E_B: begin
        cut_v(0, R);
        if (!(py[0] < B)) begin cut_h(1, B); vis = 1; end
      end
      S_R|E_B|E_L: begin
        cut_v(0, R);
        if (!(py[0] < B)) begin
          cut_h(1, B); if (px[1] < L) cut_v(1, L); vis = 1;
        end
      end
      S_R|E_T: begin
        cut_v(0, R);
        if (!(py[0] > T)) begin cut_h(1, T); vis = 1; end
      end
      S_R|E_T|E_L: begin
        cut_v(0, R);
        if (!(py[0] > T)) begin
          cut_h(1, T); if (px[1] < L) cut_v(1, L); vis = 1;
        end
      end
      S_B: begin cut_h(0, B); vis = 1; end
      S_B|E_L: begin
        cut_h(0, B);
        if (!(px[0] < L)) begin
          cut_v(1, L); if (py[1] < B) cut_h(1, B); vis = 1;
        end
      end
      S_B|E_R: begin
        cut_h(0, B);
        if (!(px[0] > R)) begin cut_v(1, R); vis = 1; end
      end
      S_B|E_T: begin cut_h(0, B); cut_h(1, T); vis = 1; end
      S_B|E_T|E_L: begin
        cut_h(0, B);
        if (!(px[0] < L)) begin
          cut_v(1, L); if (py[1] > T) cut_h(1, T); vis = 1;
        end
      end
      S_B|E_T|E_R: begin
        cut_h(0, B);
        if (!(px[0] > R)) begin
          cut_v(1, R); if (py[1] > T) cut_h(1, T); vis = 1;
        end
      end
      S_B|S_L: begin cut_v(0, L); if (py[0] < B) cut_h(0, B); vis = 1; end
      S_B|S_L|E_R: begin
        cut_v(1, R);
        if (!(py[1] < B)) begin
          cut_h(0, B); if (px[0] < L) cut_v(0, L); vis = 1;
        end
      end
      S_B|S_L|E_T: begin
        cut_h(1, T);
        if (!(px[1] < L)) begin
          cut_h(0, B); if (px[0] < L) cut_v(0, L); vis = 1;
        end
      end
      S_B|S_L|E_T|E_R: begin
        cut_v(0, L);
        if (!(py[0] > T)) begin
          cut_v(1, R);
          if (!(py[1] < B)) begin
            if (py[0] < B) cut_h(0, B);
            if (py[1] > T) cut_h(1, T);
            vis = 1;
          end
        end
      end
      S_B|S_R: begin cut_v(0, R); if (py[0] < B) cut_h(0, B); vis = 1; end
      S_B|S_R|E_L: begin
        cut_v(1, L);
        if (!(py[1] < B)) begin
          cut_h(0, B); if (px[0] > R) cut_v(0, R); vis = 1;
        end
      end
      S_B|S_R|E_T: begin
        cut_h(1, T);
        if (!(px[1] > R)) begin
          cut_v(0, R); if (py[0] < B) cut_h(0, B); vis = 1;
        end
      end
      S_B|S_R|E_T|E_L: begin
        cut_v(1, L);
        if (!(py[1] < B)) begin
          cut_v(0, R);
          if (!(py[0] > T)) begin
            if (py[1] > T) cut_h(1, T);
            if (py[0] < B) cut_h(0, B);
            vis = 1;
          end
        end
      end
      S_T: begin cut_h(0, T); vis = 1; end
      S_T|E_L: begin
        cut_h(0, T);
        if (!(px[0] < L)) begin cut_v(1, L); vis = 1; end
      end
      S_T|E_R: begin
        cut_h(0, T);
        if (!(px[0] > R)) begin cut_v(1, R); vis = 1; end
      end
      S_T|E_B: begin cut_h(0, T); cut_h(1, B); vis = 1; end
      S_T|E_B|E_L: begin
        cut_h(0, T);
        if (!(px[0] < L)) begin
          cut_v(1, L); if (py[1] < B) cut_h(1, B); vis = 1;
        end
      end
      S_T|E_B|E_R: begin
        cut_h(0, T);
        if (!(px[0] > R)) begin
          cut_v(1, R); if (py[1] < B) cut_h(1, B); vis = 1;
        end
      end
      S_T|S_L: begin cut_v(0, L); if (py[0] > T) cut_h(0, T); vis = 1; end
      S_T|S_L|E_R: begin
        cut_v(1, R);
        if (!(py[1] > T)) begin
          cut_h(0, T); if (px[0] < L) cut_v(0, L); vis = 1;
        end
      end
      S_T|S_L|E_B: begin
        cut_h(1, B);
        if (!(px[1] < L)) begin
          cut_v(0, L); if (py[0] > T) cut_h(0, T); vis = 1;
        end
      end
      S_T|S_L|E_B|E_R: begin
        cut_v(0, L);
        if (!(py[0] < B)) begin
          cut_v(1, R);
          if (!(py[1] > T)) begin
            if (py[0] > T) cut_h(0, T);
            if (py[1] < B) cut_h(1, B);
            vis = 1;
          end
        end
      end
      S_T|S_R: begin cut_v(0, R); if (py[0] > T) cut_h(0, T); vis = 1; end
      S_T|S_R|E_L: begin
        cut_v(1, L);
        if (!(py[1] > T)) begin
          cut_h(0, T); if (px[0] > R) cut_v(0, R); vis = 1;
        end
      end
      S_T|S_R|E_B: begin
        cut_h(1, B);
        if (!(px[1] > R)) begin
          cut_v(0, R); if (py[0] > T) cut_h(0, T); vis = 1;
        end
      end
      S_T|S_R|E_B|E_L: begin
        cut_v(1, L);
        if (!(py[1] > T)) begin
          cut_v(0, R);
          if (!(py[0] < B)) begin
            if (py[1] < B) cut_h(1, B);
            if (py[0] > T) cut_h(0, T);
            vis = 1;
          end
        end
      end
      default: vis = 0;
    endcase
    if (vis) begin
      c.clipped_start_x = fcl_pkg::coord_t'(px[0]);
      c.clipped_start_y = fcl_pkg::coord_t'(py[0]);
      c.clipped_end_x = fcl_pkg::coord_t'(px[1]);
      c.clipped_end_y = fcl_pkg::coord_t'(py[1]);
    end else begin
      c.clipped_start_x = ln.start_x;
      c.clipped_start_y = ln.start_y;
      c.clipped_end_x = ln.end_x;
      c.clipped_end_y = ln.end_y;
    end
    c.visible = vis;
    return c;
  endfunction

  // coordinate biased toward the window span and its edges
  function automatic fcl_pkg::coord_t pick_coord(longint a, longint b);
    longint lo, hi, span, v;
    lo = a < b ? a : b;
    hi = a < b ? b : a;
    span = hi - lo + 64;
    case ($urandom_range(0, 9))
      0, 1: v = fcl_pkg::coord_t'($urandom);
      2: v = $urandom_range(0, 1) ? lo : hi;
      3: v = $urandom_range(0, 1) ? lo - 1 : hi + 1;
      default: v = lo - span / 2 + longint'($urandom_range(0, 2 * span));
    endcase
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return fcl_pkg::coord_t'(v);
  endfunction

  function automatic fcl_pkg::line_t rand_line();
    fcl_pkg::line_t ln;
    ln.start_x = pick_coord(win_l, win_r);
    ln.start_y = pick_coord(win_b, win_t);
    ln.end_x = pick_coord(win_l, win_r);
    ln.end_y = pick_coord(win_b, win_t);
    return ln;
  endfunction

  task automatic write_reg(logic [fcl_pkg::CFG_IDX_W-1:0] idx, fcl_pkg::coord_t v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_window(fcl_pkg::coord_t l, fcl_pkg::coord_t b,
                            fcl_pkg::coord_t r, fcl_pkg::coord_t t);
    write_reg(fcl_pkg::REG_LEFT, l);
    write_reg(fcl_pkg::REG_BOTTOM, b);
    write_reg(fcl_pkg::REG_RIGHT, r);
    write_reg(fcl_pkg::REG_TOP, t);
    win_l = l; win_b = b; win_r = r; win_t = t;
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_lines.size() != 0 || start || clipped_q.size() != 0);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_lines.push_back(rand_line());
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      line_i <= '0;
    end else begin
      if (start && !busy) clipped_q.push_back(clip_line(line_i));
      if (!(start && busy)) begin
        if (pending_lines.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          start <= 1'b1;
          line_i <= pending_lines.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    fcl_pkg::clip_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (clipped_q.size() == 0) begin
          $error("unexpected beat on done_o");
          fails++;
        end else begin
          want = clipped_q.pop_front();
          if (clip_o.clipped_start_x !== want.clipped_start_x) begin
            $error("clipped_start_x exp %0d got %0d", want.clipped_start_x,
                   clip_o.clipped_start_x);
            fails++;
          end
          if (clip_o.clipped_start_y !== want.clipped_start_y) begin
            $error("clipped_start_y exp %0d got %0d", want.clipped_start_y,
                   clip_o.clipped_start_y);
            fails++;
          end
          if (clip_o.clipped_end_x !== want.clipped_end_x) begin
            $error("clipped_end_x exp %0d got %0d", want.clipped_end_x,
                   clip_o.clipped_end_x);
            fails++;
          end
          if (clip_o.clipped_end_y !== want.clipped_end_y) begin
            $error("clipped_end_y exp %0d got %0d", want.clipped_end_y,
                   clip_o.clipped_end_y);
            fails++;
          end
          if (clip_o.visible !== want.visible) begin
            $error("visible exp %0b got %0b", want.visible, clip_o.visible);
            fails++;
          end
        end
      end
      if (done_o || (start && !busy)) stall_cnt <= 0;
      else if (stall_cnt >= STALL_LIMIT) begin
        $display("FAIL fast_line_clip");
        $finish;
      end else stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window, sender idles lightly
    send_idle = 13;
    pending_lines.push_back('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
    pending_lines.push_back('{16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff});
    push_random(ITEMS_PER_PHASE);
    drain();

    set_window(-1600, -800, 1600, 800);
    pending_lines.push_back('{0, 0, 100, 100});
    pending_lines.push_back('{-2000, 0, -3000, 10});
    pending_lines.push_back('{-32768, 0, 32767, 0});
    pending_lines.push_back('{0, -32768, 0, 32767});
    pending_lines.push_back('{-32768, -32768, 32767, 32767});
    pending_lines.push_back('{32767, -32768, -32768, 32767});
    pending_lines.push_back('{-1600, -800, 1600, 800});
    pending_lines.push_back('{-1601, -801, 1601, 801});
    pending_lines.push_back('{-2000, 500, 0, 2000});
    pending_lines.push_back('{2000, -500, 0, -2000});
    pending_lines.push_back('{-3000, -3000, 3000, 3000});
    pending_lines.push_back('{3000, 3000, -3000, -3000});
    pending_lines.push_back('{-3000, 3000, 3000, -3000});
    pending_lines.push_back('{-1601, -32768, -1600, 32767});
    pending_lines.push_back('{-5000, 100, 5000, 101});
    pending_lines.push_back('{0, 900, 0, -900});
    pending_lines.push_back('{-1700, -900, -1700, 900});
    pending_lines.push_back('{2000, 0, 2500, 3000});
    push_random(ITEMS_PER_PHASE);
    drain();

    // inverted window, sender idles heavily
    send_idle = 88;
    set_window(300, 200, -300, -200);
    pending_lines.push_back('{0, 0, 0, 0});
    pending_lines.push_back('{50, 0, -150, 0});
    push_random(ITEMS_PER_PHASE);
    drain();

    set_window(-32768, -32768, 32767, 32767);
    push_random(ITEMS_PER_PHASE);
    drain();

    // degenerate then random windows, no idling
    send_idle = 0;
    set_window(16, 16, 16, 16);
    push_random(ITEMS_PER_PHASE / 2);
    drain();
    set_window(pick_coord(-4000, 0), pick_coord(-4000, 0),
               pick_coord(0, 4000), pick_coord(0, 4000));
    push_random(ITEMS_PER_PHASE / 2);
    drain();

    if (fails == 0 && clipped_q.size() == 0) begin
      $display("PASS fast_line_clip");
    end else begin
      $display("FAIL fast_line_clip");
    end
    $finish;
  end

endmodule

`default_nettype wire
